/* rtl/seq_pkg.sv */
package seq_pkg;

   localparam int DEPTH         = 16;
   localparam int KEY_WIDTH     = 32;
   localparam int PAYLOAD_WIDTH = 32;
   localparam int CNT_W         = $clog2(DEPTH + 1);
   localparam int IDX_W         = $clog2(DEPTH);

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef struct packed {
      logic ld_new;
      logic ld_left;
      logic ld_right;
   } cell_ctl_type;

endpackage

/* rtl/seq_if.sv */
interface seq_req_if;
   logic                               valid;
   logic                               ready;
   logic                               operation;
   logic [seq_pkg::KEY_WIDTH-1:0]      entry_key;
   logic [seq_pkg::PAYLOAD_WIDTH-1:0]  entry_payload;

   modport source (output valid, operation, entry_key, entry_payload, input ready);
   modport sink   (input valid, operation, entry_key, entry_payload, output ready);
endinterface

interface seq_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  status;
   logic [seq_pkg::CNT_W-1:0]   position;
   logic [seq_pkg::CNT_W-1:0]   entry_count;
   logic                        is_empty;

   modport source (output valid, status, position, entry_count, is_empty, input ready);
   modport sink   (input valid, status, position, entry_count, is_empty, output ready);
endinterface

/* rtl/seq_cell.sv */
module seq_cell (
   input  logic                                clock,
   input  seq_pkg::cell_ctl_type               ctl,
   input  logic [seq_pkg::KEY_WIDTH-1:0]       new_key,
   input  logic [seq_pkg::PAYLOAD_WIDTH-1:0]   new_payload,
   input  logic [seq_pkg::KEY_WIDTH-1:0]       left_key,
   input  logic [seq_pkg::PAYLOAD_WIDTH-1:0]   left_payload,
   input  logic [seq_pkg::KEY_WIDTH-1:0]       right_key,
   input  logic [seq_pkg::PAYLOAD_WIDTH-1:0]   right_payload,
   output logic [seq_pkg::KEY_WIDTH-1:0]       key,
   output logic [seq_pkg::PAYLOAD_WIDTH-1:0]   payload,
   output logic                                ge,
   output logic                                eq
);
   import seq_pkg::*;

   logic [KEY_WIDTH-1:0]     key_ff, key_in;
   logic [PAYLOAD_WIDTH-1:0] payload_ff, payload_in;

   always_comb begin
      priority if (ctl.ld_left) begin
         key_in     = left_key;
         payload_in = left_payload;
      end else if (ctl.ld_new) begin
         key_in     = new_key;
         payload_in = new_payload;
      end else if (ctl.ld_right) begin
         key_in     = right_key;
         payload_in = right_payload;
      end else begin
         key_in     = key_ff;
         payload_in = payload_ff;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      payload_ff <= payload_in;
   end

   assign key     = key_ff;
   assign payload = payload_ff;
   assign ge      = (key_ff >= new_key);
   assign eq      = (key_ff == new_key);

endmodule

/* rtl/sorted_event_queue.sv */
// Sorted event queue: up to DEPTH entries held in ascending order of key.
// req_chan carries one item: operation (insert or remove), entry_key and
// entry_payload. An insert lands before the first stored key that is greater
// than or equal to it; a remove deletes the first entry with an equal key.
// rsp_chan returns one item per request: status, 1-based position, entry
// count after the operation and an empty flag.
// The store is a row of cells, one per entry. Every cell compares its key
// with the request key in the same cycle and then holds, loads the new entry,
// or takes its left or right neighbour's entry, so the whole row shifts at
// once. A request is accepted at one edge and its response is registered at
// that edge; one item per cycle is sustained while each response is taken.
// The response register frees when rsp_chan is taken; while the receiver
// stalls with a response waiting, req_chan.ready is low and requests hold.
// Reset (synchronous) empties the queue and drops any waiting response; the
// cell contents are not cleared, only the count.
module sorted_event_queue (
   input logic       clock,
   input logic       reset,
   seq_req_if.sink   req_chan,
   seq_rsp_if.source rsp_chan
);
   import seq_pkg::*;

   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [1:0]               status_ff, status_in;
   logic [CNT_W-1:0]         position_ff, position_in;

   logic [KEY_WIDTH-1:0]     cell_key [DEPTH];
   logic [PAYLOAD_WIDTH-1:0] cell_payload [DEPTH];
   logic [DEPTH-1:0]         cell_ge, cell_eq, occ, gflag, edge_vec;
   cell_ctl_type             ctl [DEPTH];

   logic                     fire, full, found, ins_ok, rem_ok;
   logic [IDX_W-1:0]         pos_idx;

   assign fire = req_chan.valid && req_chan.ready;
   assign full = (count_ff == CNT_W'(DEPTH));

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         occ[i]   = (CNT_W'(i) < count_ff);
         gflag[i] = occ[i] && cell_ge[i];
      end
      for (int i = 0; i < DEPTH; i++) begin
         if (req_chan.operation == OP_REMOVE) begin
            edge_vec[i] = gflag[i] && ((i == 0) ? 1'b1 : !gflag[(i == 0) ? 0 : i - 1]);
         end else begin
            edge_vec[i] = ((i == 0) ? 1'b1 : !gflag[(i == 0) ? 0 : i - 1])
                          && (gflag[i] || (count_ff == CNT_W'(i)));
         end
      end
      pos_idx = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (edge_vec[i]) begin
            pos_idx = pos_idx | IDX_W'(i);
         end
      end
      found  = |(edge_vec & cell_eq);
      ins_ok = fire && (req_chan.operation == OP_INSERT) && !full;
      rem_ok = fire && (req_chan.operation == OP_REMOVE) && found;
      for (int i = 0; i < DEPTH; i++) begin
         ctl[i].ld_new   = ins_ok && edge_vec[i];
         ctl[i].ld_left  = ins_ok && ((i == 0) ? 1'b0 : gflag[(i == 0) ? 0 : i - 1]);
         ctl[i].ld_right = rem_ok && gflag[i];
      end
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      localparam int L = (g == 0) ? 0 : g - 1;
      localparam int R = (g == DEPTH - 1) ? g : g + 1;
      seq_cell u_cell (
         .clock         (clock),
         .ctl           (ctl[g]),
         .new_key       (req_chan.entry_key),
         .new_payload   (req_chan.entry_payload),
         .left_key      (cell_key[L]),
         .left_payload  (cell_payload[L]),
         .right_key     (cell_key[R]),
         .right_payload (cell_payload[R]),
         .key           (cell_key[g]),
         .payload       (cell_payload[g]),
         .ge            (cell_ge[g]),
         .eq            (cell_eq[g])
      );
   end

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      status_in    = status_ff;
      position_in  = position_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         unique case (req_chan.operation)
            OP_INSERT: begin
               if (full) begin
                  status_in   = ST_FULL;
                  position_in = '0;
               end else begin
                  status_in   = ST_DONE;
                  position_in = CNT_W'(pos_idx) + CNT_W'(1);
                  count_in    = count_ff + CNT_W'(1);
               end
            end
            OP_REMOVE: begin
               if (found) begin
                  status_in   = ST_DONE;
                  position_in = CNT_W'(pos_idx) + CNT_W'(1);
                  count_in    = count_ff - CNT_W'(1);
               end else begin
                  status_in   = ST_NOT_FOUND;
                  position_in = '0;
               end
            end
            default: begin
               status_in = ST_DONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff   <= status_in;
      position_ff <= position_in;
   end

   assign req_chan.ready       = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = status_ff;
   assign rsp_chan.position    = position_ff;
   assign rsp_chan.entry_count = count_ff;
   assign rsp_chan.is_empty    = (count_ff == '0);

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count beyond depth");

   a_edge_single : assert property (@(posedge clock) disable iff (reset)
      fire |-> $onehot0(edge_vec))
      else $error("more than one insertion or removal point");

   a_insert_count : assert property (@(posedge clock) disable iff (reset)
      ins_ok |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not advance count");

   a_fail_holds : assert property (@(posedge clock) disable iff (reset)
      (fire && !ins_ok && !rem_ok) |=> $stable(count_ff) && status_ff != ST_DONE)
      else $error("refused item changed the store");

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps

module testbench;
   import seq_pkg::*;

   typedef struct packed {
      status_type         status;
      logic [CNT_W-1:0]   position;
      logic [CNT_W-1:0]   entry_count;
      logic               is_empty;
   } queue_result_type;

   logic clock;
   logic reset;

   seq_req_if req_chan ();
   seq_rsp_if rsp_chan ();

   sorted_event_queue u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   logic [KEY_WIDTH-1:0]     model_keys     [DEPTH];
   logic [PAYLOAD_WIDTH-1:0] model_payloads [DEPTH];
   int                       model_count;

   queue_result_type pending_results [$];

   bit gaps_on;
   int rsp_hold;
   int fail_count;
   int mismatch_count;
   int checked_count;
   int insert_count;
   int refused_count;
   int remove_count;
   int missing_count;
   int full_hits;
   int empty_hits;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("timeout: %0d results still outstanding", pending_results.size());
      $display("TB_ERROR");
      $finish;
   end

   function automatic queue_result_type predict_queue_op(op_type op,
                                                         logic [KEY_WIDTH-1:0] key,
                                                         logic [PAYLOAD_WIDTH-1:0] payload);
      queue_result_type r;
      int               slot;
      r.status   = ST_DONE;
      r.position = '0;
      if (op == OP_INSERT) begin
         insert_count++;
         if (model_count >= DEPTH) begin
            r.status = ST_FULL;
            refused_count++;
         end else begin
            slot = model_count;
            for (int i = model_count - 1; i >= 0; i--)
               if (model_keys[i] >= key) slot = i;
            for (int i = model_count; i > slot; i--) begin
               model_keys[i]     = model_keys[i - 1];
               model_payloads[i] = model_payloads[i - 1];
            end
            model_keys[slot]     = key;
            model_payloads[slot] = payload;
            model_count++;
            r.position = CNT_W'(slot + 1);
            if (model_count == DEPTH) full_hits++;
         end
      end else begin
         remove_count++;
         slot = -1;
         for (int i = model_count - 1; i >= 0; i--)
            if (model_keys[i] == key) slot = i;
         if (slot < 0) begin
            r.status = ST_NOT_FOUND;
            missing_count++;
         end else begin
            for (int i = slot; i + 1 < model_count; i++) begin
               model_keys[i]     = model_keys[i + 1];
               model_payloads[i] = model_payloads[i + 1];
            end
            model_count--;
            r.position = CNT_W'(slot + 1);
            if (model_count == 0) empty_hits++;
         end
      end
      r.entry_count = CNT_W'(model_count);
      r.is_empty    = (model_count == 0);
      return r;
   endfunction

   function automatic logic [KEY_WIDTH-1:0] pick_key();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return KEY_WIDTH'($urandom_range(0, 15));
         4:          return ($urandom_range(0, 1) != 0) ? '1 : '0;
         default:    return $urandom();
      endcase
   endfunction

   function automatic logic [KEY_WIDTH-1:0] pick_remove_key();
      if (model_count > 0 && $urandom_range(0, 3) != 0)
         return model_keys[$urandom_range(0, model_count - 1)];
      return pick_key();
   endfunction

   task automatic send_item(op_type op, logic [KEY_WIDTH-1:0] key,
                            logic [PAYLOAD_WIDTH-1:0] payload);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.operation     <= op;
      req_chan.entry_key     <= key;
      req_chan.entry_payload <= payload;
      do @(posedge clock); while (!req_chan.ready);
      pending_results.push_back(predict_queue_op(op, key, payload));
   endtask

   task automatic wait_for_responses();
      int guard;
      guard = 0;
      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
   endtask

   // receiver: random short stalls while gaps_on is set, long hold while rsp_hold runs
   initial begin
      int gap;
      gap = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold > 0) begin
            rsp_chan.ready <= 1'b0;
            rsp_hold--;
         end else if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            gap--;
         end else if (gaps_on && $urandom_range(0, 4) == 0) begin
            rsp_chan.ready <= 1'b0;
            gap = $urandom_range(0, 2);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      queue_result_type want;
      queue_result_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.status      = status_type'(rsp_chan.status);
         got.position    = rsp_chan.position;
         got.entry_count = rsp_chan.entry_count;
         got.is_empty    = rsp_chan.is_empty;
         if (pending_results.size() == 0) begin
            fail_count++;
            $display("response with nothing outstanding: status %0d pos %0d count %0d",
                     got.status, got.position, got.entry_count);
         end else begin
            want = pending_results.pop_front();
            checked_count++;
            if (got.status !== want.status || got.position !== want.position ||
                got.entry_count !== want.entry_count || got.is_empty !== want.is_empty) begin
               fail_count++;
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch at result %0d: expected status %0d pos %0d count %0d empty %0b",
                           checked_count, want.status, want.position, want.entry_count,
                           want.is_empty);
                  $display("   got status %0d pos %0d count %0d empty %0b",
                           got.status, got.position, got.entry_count, got.is_empty);
               end
            end
         end
      end
   end

   task automatic test_edge_cases();
      send_item(OP_REMOVE, '0, '0);
      send_item(OP_INSERT, '0, '1);
      send_item(OP_INSERT, '1, '0);
      send_item(OP_INSERT, 32'h8000_0000, 32'hA5A5_5A5A);
      send_item(OP_INSERT, 32'h8000_0000, 32'h5A5A_A5A5);
      send_item(OP_REMOVE, 32'h0000_1234, '1);
      send_item(OP_REMOVE, 32'h8000_0000, '0);
      send_item(OP_REMOVE, '1, '0);
      send_item(OP_REMOVE, '0, '0);
      send_item(OP_REMOVE, 32'h8000_0000, '0);
   endtask

   task automatic test_full_store();
      for (int i = 0; i < DEPTH; i++)
         send_item(OP_INSERT, pick_key(), $urandom());
      send_item(OP_INSERT, '0, '1);
      send_item(OP_REMOVE, model_keys[DEPTH / 2], '0);
   endtask

   task automatic test_random_traffic(int n, int insert_pct);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(1, 100) <= insert_pct)
            send_item(OP_INSERT, pick_key(), $urandom());
         else
            send_item(OP_REMOVE, pick_remove_key(), $urandom());
      end
   endtask

   // hold the receiver while items keep arriving
   task automatic test_backpressure();
      rsp_hold = 60;
      test_random_traffic(20, 60);
   endtask

   initial begin
      reset                  <= 1'b1;
      req_chan.valid         <= 1'b0;
      req_chan.operation     <= OP_INSERT;
      req_chan.entry_key     <= '0;
      req_chan.entry_payload <= '0;
      gaps_on  = 1'b1;
      rsp_hold = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_edge_cases();
      wait_for_responses();
      test_full_store();
      wait_for_responses();
      test_random_traffic(500, 70);
      test_backpressure();
      wait_for_responses();
      test_random_traffic(500, 30);
      wait_for_responses();
      test_random_traffic(500, 52);
      wait_for_responses();
      gaps_on = 1'b0;
      test_random_traffic(350, 55);
      wait_for_responses();
      repeat (4) @(posedge clock);

      if (pending_results.size() != 0) begin
         fail_count += pending_results.size();
         $display("%0d expected results never arrived", pending_results.size());
      end
      $display("Covered %0d inserts (%0d refused, store full) and %0d removes (%0d keys absent).",
               insert_count, refused_count, remove_count, missing_count);
      $display("Store filled %0d times and emptied %0d times; %0d results checked, %0d bad.",
               full_hits, empty_hits, checked_count, fail_count);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

/* sim.f */
rtl/seq_pkg.sv
rtl/seq_if.sv
rtl/seq_cell.sv
rtl/sorted_event_queue.sv
sim/testbench.sv
